// File: sv/segment_view_transform_clip_top_assert.svh
// ----------------------------------------------------------------------------
// Segment view transform and clip: assertion macros
// Shorthand for the concurrent checks used on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_VIEW_TRANSFORM_CLIP_TOP_ASSERT_SVH
`define SEGMENT_VIEW_TRANSFORM_CLIP_TOP_ASSERT_SVH

// Overlapping implication, checked out of reset.
`define SVTC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("segment clip check failed");

// Implication checked in the next cycle, out of reset.
`define SVTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("segment clip check failed");

`endif

// File: sv/svtc_pkg.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: package
// Shared constants, register indexes and the cut control type.
// ----------------------------------------------------------------------------
package svtc_pkg;

    // Default parameter values.
    localparam int PIXEL_BITS_DEF    = 12;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int WORLD_BITS    = 32;
    localparam int SCALE_BITS    = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Number of clip iterations a segment may take.
    localparam int MAX_CUTS = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_SCALE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd4;

    // Register reset values.
    localparam logic [SCALE_BITS-1:0] VIEW_SCALE_RESET = 32'd65536;
    localparam int WINDOW_WIDTH_RESET  = 1024;
    localparam int WINDOW_HEIGHT_RESET = 768;

    // Positions of the four coordinates in a point array.
    localparam int PT_COUNT = 4;
    localparam int PT_X0 = 0;
    localparam int PT_Y0 = 1;
    localparam int PT_X1 = 2;
    localparam int PT_Y1 = 3;

    // Outcode bits.
    localparam int OC_LEFT   = 0;
    localparam int OC_RIGHT  = 1;
    localparam int OC_TOP    = 2;
    localparam int OC_BOTTOM = 3;

    // Control that travels with a segment through the clip chain.
    typedef struct packed {
        logic done;     // segment accepted or rejected
        logic vis;      // accepted segment
        logic active;   // a cut is under way in this iteration
        logic sel_end;  // 0: start point moves, 1: end point moves
        logic x_axis;   // cut on a vertical edge
        logic neg;      // quotient sign
    } cut_ctl_t;

endpackage

// File: sv/svtc_xform.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: view transform
// Maps the four world coordinates to screen fixed point in two stages.
// ----------------------------------------------------------------------------
module svtc_xform import svtc_pkg::*; #(
    parameter int FB = FRACTION_BITS_DEF,
    parameter int CW = 2 * WORLD_BITS + 1 - FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [WORLD_BITS-1:0] in_world [PT_COUNT],
    input  logic        [SCALE_BITS-1:0] scale,
    input  logic signed [WORLD_BITS-1:0] off_x,
    input  logic signed [WORLD_BITS-1:0] off_y,
    output logic                         out_valid,
    output logic signed [CW-1:0]         out_pt [PT_COUNT]
);

    localparam int PW = WORLD_BITS + SCALE_BITS;

    logic                 prod_valid_reg;
    logic signed [PW-1:0] prod_reg  [PT_COUNT];
    logic signed [PW-1:0] prod_next [PT_COUNT];
    logic                 pt_valid_reg;
    logic signed [CW-1:0] pt_reg  [PT_COUNT];
    logic signed [CW-1:0] pt_next [PT_COUNT];

    // Exact product of world coordinate and zoom factor.
    always_comb begin
        for (int i = 0; i < PT_COUNT; i++) begin
            prod_next[i] = PW'(in_world[i] * $signed({1'b0, scale}));
        end
    end

    // Floor shift to screen units, then add the pan offset.
    always_comb begin
        for (int i = 0; i < PT_COUNT; i++) begin
            if (i[0] == 1'b0) begin
                pt_next[i] = CW'(prod_reg[i] >>> FB) + CW'(off_x);
            end else begin
                pt_next[i] = CW'(prod_reg[i] >>> FB) + CW'(off_y);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            pt_valid_reg   <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= in_valid;
            pt_valid_reg   <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            pt_reg   <= pt_next;
        end
    end

    assign out_valid = pt_valid_reg;
    assign out_pt    = pt_reg;

endmodule

// File: sv/svtc_cut_prep.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: cut preparation
// Outcode test and choice of the cut, then the exact product of the
// interpolation numerator, in three stages.
// ----------------------------------------------------------------------------
module svtc_cut_prep import svtc_pkg::*; #(
    parameter int PB = PIXEL_BITS_DEF,
    parameter int FB = FRACTION_BITS_DEF,
    parameter int CW = 2 * WORLD_BITS + 1 - FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cut_ctl_t             in_ctl,
    input  logic signed [CW-1:0] in_pt [PT_COUNT],
    input  logic [PB-1:0]        win_w,
    input  logic [PB-1:0]        win_h,
    output logic                 out_valid,
    output cut_ctl_t             out_ctl,
    output logic signed [CW-1:0] out_pt [PT_COUNT],
    output logic signed [CW-1:0] out_edge,
    output logic [2*CW-1:0]      out_prod,
    output logic [CW-1:0]        out_dmag
);

    localparam int DW = CW + 1;
    localparam int H  = (CW + 1) / 2;

    // Stage A: outcodes and cut operands.
    logic signed [CW-1:0] w_fx, h_fx;
    logic [3:0]           code0, code1, code_sel, code_low;
    logic                 x_axis, low_edge;
    logic [1:0]           ax_i, ot_i, qax_i, qot_i;
    cut_ctl_t             a_ctl_next;
    logic signed [CW-1:0] a_edge_next;
    logic signed [DW-1:0] a_num_next, a_frac_next, a_den_next;

    logic                 a_valid_reg;
    cut_ctl_t             a_ctl_reg;
    logic signed [CW-1:0] a_pt_reg [PT_COUNT];
    logic signed [CW-1:0] a_edge_reg;
    logic signed [DW-1:0] a_num_reg, a_frac_reg, a_den_reg;

    // Stage B: magnitudes and partial products.
    logic [DW-1:0]        num_abs, frac_abs, den_abs;
    logic [CW-1:0]        num_mag, frac_mag;
    logic [H-1:0]         nl, nh, fl, fh;
    logic [2*H-1:0]       pp_next [4];
    cut_ctl_t             b_ctl_next;

    logic                 b_valid_reg;
    cut_ctl_t             b_ctl_reg;
    logic signed [CW-1:0] b_pt_reg [PT_COUNT];
    logic signed [CW-1:0] b_edge_reg;
    logic [2*H-1:0]       b_pp_reg [4];
    logic [CW-1:0]        b_dmag_reg;

    // Stage C: full product.
    logic [2*CW-1:0]      c_prod_next;
    logic                 c_valid_reg;
    cut_ctl_t             c_ctl_reg;
    logic signed [CW-1:0] c_pt_reg [PT_COUNT];
    logic signed [CW-1:0] c_edge_reg;
    logic [2*CW-1:0]      c_prod_reg;
    logic [CW-1:0]        c_dmag_reg;

    assign w_fx = CW'({win_w, {FB{1'b0}}});
    assign h_fx = CW'({win_h, {FB{1'b0}}});

    // Outcodes of both points and the edge to cut against.
    always_comb begin
        code0 = {in_pt[PT_Y0] > h_fx, in_pt[PT_Y0][CW-1],
                 in_pt[PT_X0] > w_fx, in_pt[PT_X0][CW-1]};
        code1 = {in_pt[PT_Y1] > h_fx, in_pt[PT_Y1][CW-1],
                 in_pt[PT_X1] > w_fx, in_pt[PT_X1][CW-1]};
        code_sel = (code0 != 4'd0) ? code0 : code1;
        code_low = code_sel & (~code_sel + 4'd1);
        x_axis   = code_low[OC_LEFT] | code_low[OC_RIGHT];
        low_edge = x_axis ? code_low[OC_LEFT] : code_low[OC_TOP];

        // The moving point is p, the other one is q.
        ax_i  = {code0 == 4'd0, ~x_axis};
        ot_i  = {code0 == 4'd0, x_axis};
        qax_i = {code0 != 4'd0, ~x_axis};
        qot_i = {code0 != 4'd0, x_axis};

        if (low_edge) begin
            a_edge_next = '0;
        end else if (x_axis) begin
            a_edge_next = w_fx;
        end else begin
            a_edge_next = h_fx;
        end

        a_num_next  = DW'(in_pt[qot_i]) - DW'(in_pt[ot_i]);
        a_frac_next = DW'(a_edge_next) - DW'(in_pt[ax_i]);
        a_den_next  = DW'(in_pt[qax_i]) - DW'(in_pt[ax_i]);

        // Trivial accept, trivial reject or a cut.
        a_ctl_next        = in_ctl;
        a_ctl_next.active = 1'b0;
        a_ctl_next.neg    = 1'b0;
        if (!in_ctl.done) begin
            if ((code0 | code1) == 4'd0) begin
                a_ctl_next.done = 1'b1;
                a_ctl_next.vis  = 1'b1;
            end else if ((code0 & code1) != 4'd0) begin
                a_ctl_next.done = 1'b1;
                a_ctl_next.vis  = 1'b0;
            end else begin
                a_ctl_next.active  = 1'b1;
                a_ctl_next.sel_end = (code0 == 4'd0);
                a_ctl_next.x_axis  = x_axis;
            end
        end
    end

    // Sign of the quotient and split magnitudes for the multiplier.
    always_comb begin
        num_abs  = a_num_reg[DW-1]  ? DW'(-a_num_reg)  : DW'(a_num_reg);
        frac_abs = a_frac_reg[DW-1] ? DW'(-a_frac_reg) : DW'(a_frac_reg);
        den_abs  = a_den_reg[DW-1]  ? DW'(-a_den_reg)  : DW'(a_den_reg);
        num_mag  = num_abs[CW-1:0];
        frac_mag = frac_abs[CW-1:0];
        nl = num_mag[H-1:0];
        nh = H'(num_mag[CW-1:H]);
        fl = frac_mag[H-1:0];
        fh = H'(frac_mag[CW-1:H]);
        pp_next[0] = (2*H)'(nl) * (2*H)'(fl);
        pp_next[1] = (2*H)'(nl) * (2*H)'(fh);
        pp_next[2] = (2*H)'(nh) * (2*H)'(fl);
        pp_next[3] = (2*H)'(nh) * (2*H)'(fh);
        b_ctl_next     = a_ctl_reg;
        b_ctl_next.neg = (a_num_reg[DW-1] ^ a_frac_reg[DW-1]) ^ a_den_reg[DW-1];
    end

    // Sum of the partial products.
    always_comb begin
        c_prod_next = (2*CW)'(b_pp_reg[0])
                    + (((2*CW)'(b_pp_reg[1]) + (2*CW)'(b_pp_reg[2])) << H)
                    + ((2*CW)'(b_pp_reg[3]) << (2*H));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctl_reg  <= a_ctl_next;
            a_pt_reg   <= in_pt;
            a_edge_reg <= a_edge_next;
            a_num_reg  <= a_num_next;
            a_frac_reg <= a_frac_next;
            a_den_reg  <= a_den_next;

            b_ctl_reg  <= b_ctl_next;
            b_pt_reg   <= a_pt_reg;
            b_edge_reg <= a_edge_reg;
            b_pp_reg   <= pp_next;
            b_dmag_reg <= den_abs[CW-1:0];

            c_ctl_reg  <= b_ctl_reg;
            c_pt_reg   <= b_pt_reg;
            c_edge_reg <= b_edge_reg;
            c_prod_reg <= c_prod_next;
            c_dmag_reg <= b_dmag_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_ctl   = c_ctl_reg;
    assign out_pt    = c_pt_reg;
    assign out_edge  = c_edge_reg;
    assign out_prod  = c_prod_reg;
    assign out_dmag  = c_dmag_reg;

endmodule

// File: sv/svtc_div_cell.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: divider cell
// One restoring division step; the remainder and the dividend bits that
// are left share one register with the quotient bits found so far.
// ----------------------------------------------------------------------------
module svtc_div_cell import svtc_pkg::*; #(
    parameter int CW = 2 * WORLD_BITS + 1 - FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cut_ctl_t             in_ctl,
    input  logic signed [CW-1:0] in_pt [PT_COUNT],
    input  logic signed [CW-1:0] in_edge,
    input  logic [2*CW-1:0]      in_rq,
    input  logic [CW-1:0]        in_dmag,
    output logic                 out_valid,
    output cut_ctl_t             out_ctl,
    output logic signed [CW-1:0] out_pt [PT_COUNT],
    output logic signed [CW-1:0] out_edge,
    output logic [2*CW-1:0]      out_rq,
    output logic [CW-1:0]        out_dmag
);

    logic [CW:0]          trial, diff;
    logic                 fits;
    logic [2*CW-1:0]      rq_next;

    logic                 valid_reg;
    cut_ctl_t             ctl_reg;
    logic signed [CW-1:0] pt_reg [PT_COUNT];
    logic signed [CW-1:0] edge_reg;
    logic [2*CW-1:0]      rq_reg;
    logic [CW-1:0]        dmag_reg;

    // Shift in the next dividend bit and subtract where the divisor fits.
    always_comb begin
        trial   = {in_rq[2*CW-1:CW], in_rq[CW-1]};
        diff    = trial - {1'b0, in_dmag};
        fits    = (trial >= {1'b0, in_dmag});
        rq_next = {fits ? diff[CW-1:0] : trial[CW-1:0], in_rq[CW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg  <= in_ctl;
            pt_reg   <= in_pt;
            edge_reg <= in_edge;
            rq_reg   <= rq_next;
            dmag_reg <= in_dmag;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_pt    = pt_reg;
    assign out_edge  = edge_reg;
    assign out_rq    = rq_reg;
    assign out_dmag  = dmag_reg;

endmodule

// File: sv/svtc_cut_apply.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: cut update
// Moves the chosen point onto its edge and steps its other coordinate by
// the signed quotient.
// ----------------------------------------------------------------------------
module svtc_cut_apply import svtc_pkg::*; #(
    parameter int CW = 2 * WORLD_BITS + 1 - FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cut_ctl_t             in_ctl,
    input  logic signed [CW-1:0] in_pt [PT_COUNT],
    input  logic signed [CW-1:0] in_edge,
    input  logic [CW-1:0]        in_quot,
    output logic                 out_valid,
    output cut_ctl_t             out_ctl,
    output logic signed [CW-1:0] out_pt [PT_COUNT]
);

    logic signed [CW:0]   delta;
    logic [1:0]           ax_i, ot_i;
    logic signed [CW-1:0] pt_next [PT_COUNT];
    cut_ctl_t             ctl_next;

    logic                 valid_reg;
    cut_ctl_t             ctl_reg;
    logic signed [CW-1:0] pt_reg [PT_COUNT];

    // New point: on the edge, other coordinate moved by the quotient.
    always_comb begin
        delta = in_ctl.neg ? -$signed({1'b0, in_quot}) : $signed({1'b0, in_quot});
        ax_i  = {in_ctl.sel_end, ~in_ctl.x_axis};
        ot_i  = {in_ctl.sel_end, in_ctl.x_axis};
        pt_next = in_pt;
        if (in_ctl.active) begin
            pt_next[ot_i] = CW'((CW+1)'(in_pt[ot_i]) + delta);
            pt_next[ax_i] = in_edge;
        end
        ctl_next        = in_ctl;
        ctl_next.active = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_next;
            pt_reg  <= pt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_pt    = pt_reg;

endmodule

// File: sv/segment_view_transform_clip_top.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: top level
// Takes one world-space segment per transaction on the s_ channel, maps
// both ends to screen space with the configured zoom and pan, clips the
// segment to the window and returns it in whole pixels on the m_ channel
// with a visible flag; a rejected segment comes back with zero coordinates.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata, which the user must do only while no segment is in flight, as the block itself does not enforce it.
// Throughput is one segment per cycle while s_ready is high. The path runs
// through two transform stages, then for each of the 16 clip
// iterations three preparation stages, one divider cell per quotient bit
// and one update stage, then the output register.
// Reset clears all valid flags and loads the register defaults.
// When the receiver stalls, one more result is caught in a skid register;
// then s_ready falls and the whole chain holds until m_ready returns.
// ----------------------------------------------------------------------------
module segment_view_transform_clip_top import svtc_pkg::*; #(
    parameter int PIXEL_BITS    = PIXEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [WORLD_BITS-1:0] s_start_x,
    input  logic signed [WORLD_BITS-1:0] s_start_y,
    input  logic signed [WORLD_BITS-1:0] s_end_x,
    input  logic signed [WORLD_BITS-1:0] s_end_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_visible,
    output logic [PIXEL_BITS-1:0]        m_screen_start_x,
    output logic [PIXEL_BITS-1:0]        m_screen_start_y,
    output logic [PIXEL_BITS-1:0]        m_screen_end_x,
    output logic [PIXEL_BITS-1:0]        m_screen_end_y
);

    localparam int PB = PIXEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int CW = WORLD_BITS + SCALE_BITS + 1 - FB;

    // Configuration registers.
    logic [SCALE_BITS-1:0]        view_scale_reg;
    logic signed [WORLD_BITS-1:0] offset_x_reg, offset_y_reg;
    logic [PB-1:0]                window_width_reg, window_height_reg;

    // Chain between clip iterations.
    logic                 en;
    logic signed [WORLD_BITS-1:0] world [PT_COUNT];
    logic                 valid_c [MAX_CUTS+1];
    cut_ctl_t             ctl_c   [MAX_CUTS+1];
    logic signed [CW-1:0] pt_c    [MAX_CUTS+1][PT_COUNT];

    // Result, output register and skid register.
    logic          fin_vis;
    logic [PB-1:0] fin_xy [PT_COUNT];
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic          out_vis_reg, out_vis_next;
    logic          skid_vis_reg, skid_vis_next;
    logic [PB-1:0] out_xy_reg  [PT_COUNT];
    logic [PB-1:0] out_xy_next [PT_COUNT];
    logic [PB-1:0] skid_xy_reg  [PT_COUNT];
    logic [PB-1:0] skid_xy_next [PT_COUNT];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_scale_reg    <= VIEW_SCALE_RESET;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            window_width_reg  <= PB'(WINDOW_WIDTH_RESET);
            window_height_reg <= PB'(WINDOW_HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_VIEW_SCALE: begin
                    view_scale_reg <= cfg_wdata;
                end
                REG_OFFSET_X: begin
                    offset_x_reg <= cfg_wdata;
                end
                REG_OFFSET_Y: begin
                    offset_y_reg <= cfg_wdata;
                end
                REG_WINDOW_WIDTH: begin
                    window_width_reg <= cfg_wdata[PB-1:0];
                end
                REG_WINDOW_HEIGHT: begin
                    window_height_reg <= cfg_wdata[PB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The chain moves whenever the skid register is empty.
    assign en      = !skid_valid_reg;
    assign s_ready = !skid_valid_reg;

    assign world[PT_X0] = s_start_x;
    assign world[PT_Y0] = s_start_y;
    assign world[PT_X1] = s_end_x;
    assign world[PT_Y1] = s_end_y;

    svtc_xform #(
        .FB (FB),
        .CW (CW)
    ) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_world  (world),
        .scale     (view_scale_reg),
        .off_x     (offset_x_reg),
        .off_y     (offset_y_reg),
        .out_valid (valid_c[0]),
        .out_pt    (pt_c[0])
    );

    assign ctl_c[0] = '0;

    // One clip iteration per stage group: prepare, divide, update.
    for (genvar g = 0; g < MAX_CUTS; g++) begin : g_cut
        logic                 dv   [CW+1];
        cut_ctl_t             dctl [CW+1];
        logic signed [CW-1:0] dpt  [CW+1][PT_COUNT];
        logic signed [CW-1:0] dedge[CW+1];
        logic [2*CW-1:0]      drq  [CW+1];
        logic [CW-1:0]        ddm  [CW+1];

        svtc_cut_prep #(
            .PB (PB),
            .FB (FB),
            .CW (CW)
        ) u_prep (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_c[g]),
            .in_ctl    (ctl_c[g]),
            .in_pt     (pt_c[g]),
            .win_w     (window_width_reg),
            .win_h     (window_height_reg),
            .out_valid (dv[0]),
            .out_ctl   (dctl[0]),
            .out_pt    (dpt[0]),
            .out_edge  (dedge[0]),
            .out_prod  (drq[0]),
            .out_dmag  (ddm[0])
        );

        for (genvar k = 0; k < CW; k++) begin : g_div
            svtc_div_cell #(
                .CW (CW)
            ) u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (dv[k]),
                .in_ctl    (dctl[k]),
                .in_pt     (dpt[k]),
                .in_edge   (dedge[k]),
                .in_rq     (drq[k]),
                .in_dmag   (ddm[k]),
                .out_valid (dv[k+1]),
                .out_ctl   (dctl[k+1]),
                .out_pt    (dpt[k+1]),
                .out_edge  (dedge[k+1]),
                .out_rq    (drq[k+1]),
                .out_dmag  (ddm[k+1])
            );
        end

        svtc_cut_apply #(
            .CW (CW)
        ) u_apply (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv[CW]),
            .in_ctl    (dctl[CW]),
            .in_pt     (dpt[CW]),
            .in_edge   (dedge[CW]),
            .in_quot   (drq[CW][CW-1:0]),
            .out_valid (valid_c[g+1]),
            .out_ctl   (ctl_c[g+1]),
            .out_pt    (pt_c[g+1])
        );
    end

    // Whole pixels of an accepted segment, zero otherwise.
    always_comb begin
        fin_vis = ctl_c[MAX_CUTS].done & ctl_c[MAX_CUTS].vis;
        for (int i = 0; i < PT_COUNT; i++) begin
            fin_xy[i] = fin_vis ? pt_c[MAX_CUTS][i][FB+PB-1:FB] : '0;
        end
    end

    // Output register with a one-entry skid behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_vis_next    = out_vis_reg;
        out_xy_next     = out_xy_reg;
        skid_vis_next   = skid_vis_reg;
        skid_xy_next    = skid_xy_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_vis_next    = skid_vis_reg;
                out_xy_next     = skid_xy_reg;
                skid_valid_next = 1'b0;
            end
        end else if (valid_c[MAX_CUTS]) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_next = 1'b1;
                out_vis_next   = fin_vis;
                out_xy_next    = fin_xy;
            end else begin
                skid_valid_next = 1'b1;
                skid_vis_next   = fin_vis;
                skid_xy_next    = fin_xy;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_vis_reg  <= out_vis_next;
        out_xy_reg   <= out_xy_next;
        skid_vis_reg <= skid_vis_next;
        skid_xy_reg  <= skid_xy_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_visible        = out_vis_reg;
    assign m_screen_start_x = out_xy_reg[PT_X0];
    assign m_screen_start_y = out_xy_reg[PT_Y0];
    assign m_screen_end_x   = out_xy_reg[PT_X1];
    assign m_screen_end_y   = out_xy_reg[PT_Y1];

endmodule

// File: sv/segment_view_transform_clip_chk.sv
// ----------------------------------------------------------------------------
// Segment view transform and clip: port checker
// Checks the result channel and the skid behavior seen at the ports.
// ----------------------------------------------------------------------------
`include "segment_view_transform_clip_top_assert.svh"

module segment_view_transform_clip_chk import svtc_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_visible,
    input logic [PIXEL_BITS-1:0] m_screen_start_x,
    input logic [PIXEL_BITS-1:0] m_screen_start_y,
    input logic [PIXEL_BITS-1:0] m_screen_end_x,
    input logic [PIXEL_BITS-1:0] m_screen_end_y
);

    // A rejected segment carries zero coordinates.
    `SVTC_ASSERT_NOW(a_invisible_zero, aclk, aresetn, m_valid && !m_visible,
        m_screen_start_x == '0 && m_screen_start_y == '0 &&
        m_screen_end_x == '0 && m_screen_end_y == '0)

    // A stalled result stays offered.
    `SVTC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Input back pressure only while a result is waiting.
    `SVTC_ASSERT_NOW(a_stall_has_result, aclk, aresetn, !s_ready, m_valid)

    // A taken result frees the skid entry at once.
    `SVTC_ASSERT_NEXT(a_skid_drains, aclk, aresetn, !s_ready && m_ready, s_ready)

endmodule

bind segment_view_transform_clip_top segment_view_transform_clip_chk #(
    .PIXEL_BITS (PIXEL_BITS)
) u_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_visible        (m_visible),
    .m_screen_start_x (m_screen_start_x),
    .m_screen_start_y (m_screen_start_y),
    .m_screen_end_x   (m_screen_end_x),
    .m_screen_end_y   (m_screen_end_y)
);
